// ===== rtl/cct_pkg.sv =====
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types, codes and the byte classifier of the character class tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package cct_pkg;

   localparam int MAX_TOKEN_LEN_DEF = 1023;
   localparam int OFFSET_WIDTH_DEF  = 32;
   localparam int FIFO_DEPTH        = 4;

   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_AT      = 8'h40;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;

   localparam logic [2:0] TY_NUM    = 3'd0;
   localparam logic [2:0] TY_ID     = 3'd1;
   localparam logic [2:0] TY_KW     = 3'd2;
   localparam logic [2:0] TY_ASSIGN = 3'd3;
   localparam logic [2:0] TY_STR    = 3'd4;
   localparam logic [2:0] TY_OP     = 3'd5;

   localparam logic [1:0] RK_TOKEN = 2'd0;
   localparam logic [1:0] RK_ERROR = 2'd1;
   localparam logic [1:0] RK_OVFL  = 2'd2;

   typedef enum logic [2:0] {
      ST_START,
      ST_NUM,
      ST_ID,
      ST_KW,
      ST_ASSIGN,
      ST_STR,
      ST_ERR
   } cct_scan_type;

   typedef enum logic [3:0] {
      CL_BAD,
      CL_OP,
      CL_SEP,
      CL_DIGIT,
      CL_ALPHA,
      CL_COLON,
      CL_EQ,
      CL_SPECIAL,
      CL_QUOTE
   } cct_class_type;

   typedef struct packed {
      logic [15:0] line;
      logic [9:0]  length;
      logic [31:0] start;
      logic [2:0]  ttype;
      logic [1:0]  kind;
   } cct_res_type;

   typedef struct packed {
      cct_res_type r0;
      cct_res_type r1;
      logic        two;
   } cct_entry_type;

   function automatic cct_class_type classify(input logic [7:0] c);
      cct_class_type cl;
      cl = CL_BAD;
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_SEMI || c == CH_COMMA)
         cl = CL_SEP;
      else if (c inside {[8'h30:8'h39]})
         cl = CL_DIGIT;
      else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]})
         cl = CL_ALPHA;
      else if (c inside {CH_DOLLAR, CH_AT, CH_QUEST})
         cl = CL_SPECIAL;
      else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PERCENT, CH_LT,
                         CH_GT, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK})
         cl = CL_OP;
      else if (c == CH_EQUAL)
         cl = CL_EQ;
      else if (c == CH_COLON)
         cl = CL_COLON;
      else if (c == CH_QUOTE)
         cl = CL_QUOTE;
      return cl;
   endfunction

   function automatic cct_res_type make_res(input logic [2:0] ttype,
                                            input logic [31:0] start,
                                            input logic [9:0] length,
                                            input logic [15:0] line,
                                            input logic [1:0] kind);
      cct_res_type r;
      r.ttype  = ttype;
      r.start  = start;
      r.length = length;
      r.line   = line;
      r.kind   = kind;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/char_class_tokenizer.sv =====
// ----------------------------------------------------------------------------
// char_class_tokenizer
// Streaming tokenizer: one source byte per transaction in, token reports out.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while req_tready is high and
// updates its scanner in that same cycle. Each byte yields zero, one or two
// results, which go into a four-entry queue and leave through a registered
// output stage at one result per cycle while rsp_tready is high. With the
// queue and the output stage empty, a byte's results enter the queue as the
// byte is taken and pass to the output register before they are offered. The
// output rate of one result per cycle is what limits throughput: long runs of
// bytes that each yield two results fill the queue, and req_tready then drops
// until it drains. After a lexical error the block reports nothing more until reset.
`default_nettype none

module char_class_tokenizer #(
   parameter int MAX_TOKEN_LEN = cct_pkg::MAX_TOKEN_LEN_DEF,
   parameter int OFFSET_WIDTH  = cct_pkg::OFFSET_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // char_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // token_type, token_start, token_length, token_line
   output logic [1:0]       rsp_tuser,   // report_kind
   output logic             rsp_tlast    // last_of_run
);

   cct_pkg::cct_entry_type push_data, pop_data;
   logic                   push, pop, full, empty, accept;

   assign req_tready = !full;
   assign accept     = req_tvalid && !full;

   cct_front #(
      .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
      .OFFSET_WIDTH  (OFFSET_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .char_in (req_tdata),
      .entry   (push_data),
      .push    (push)
   );

   cct_fifo #(
      .DEPTH (cct_pkg::FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   cct_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_data   (pop_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/cct_front.sv =====
// ----------------------------------------------------------------------------
// cct_front
// Classifies each input byte, advances the scanner and builds up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_front #(
   parameter int MAX_TOKEN_LEN = cct_pkg::MAX_TOKEN_LEN_DEF,
   parameter int OFFSET_WIDTH  = cct_pkg::OFFSET_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            char_in,
   output cct_pkg::cct_entry_type     entry,
   output logic                       push
);

   localparam int RL_W = $clog2(MAX_TOKEN_LEN + 2);
   localparam logic [RL_W-1:0] RL_MAX = RL_W'(MAX_TOKEN_LEN);

   cct_pkg::cct_scan_type   scan_ff, scan_in;
   logic                    held_ff, held_in;
   logic                    colon_ff, colon_in;
   logic [OFFSET_WIDTH-1:0] start_ff, start_in;
   logic [RL_W-1:0]         rl_ff, rl_in;
   logic [15:0]             line_ff, line_in;
   logic [OFFSET_WIDTH-1:0] off_ff, off_in;

   cct_pkg::cct_class_type  cl;
   logic [RL_W-1:0]         rl_grow;
   logic [RL_W-1:0]         wlen;
   logic [31:0]             wlen_wide;
   logic [OFFSET_WIDTH-1:0] prev_off;
   logic [63:0]             cur_wide, prev_wide, start_wide;
   logic [2:0]              word_type;
   cct_pkg::cct_res_type    word_res, err_res, op_cur, op_prev, asg_prev, asg_start;
   logic                    cont, holds;
   cct_pkg::cct_res_type    r0, r1;
   logic [1:0]              n;

   assign cl         = cct_pkg::classify(char_in);
   assign line_in    = (char_in == cct_pkg::CH_LF && line_ff != 16'hFFFF) ?
                       line_ff + 16'd1 : line_ff;
   assign off_in     = off_ff + OFFSET_WIDTH'(1);
   assign rl_grow    = (rl_ff <= RL_MAX) ? rl_ff + RL_W'(1) : rl_ff;
   assign prev_off   = off_ff - OFFSET_WIDTH'(1);
   assign cur_wide   = 64'(off_ff);
   assign prev_wide  = 64'(prev_off);
   assign start_wide = 64'(start_ff);

   assign cont  = (cl == cct_pkg::CL_DIGIT && scan_ff != cct_pkg::ST_KW) ||
                  (cl == cct_pkg::CL_ALPHA && scan_ff != cct_pkg::ST_NUM);
   assign holds = cl == cct_pkg::CL_OP || cl == cct_pkg::CL_EQ ||
                  (cl == cct_pkg::CL_COLON && scan_ff == cct_pkg::ST_ID);

   always_comb begin
      word_type = cct_pkg::TY_ID;
      if (scan_ff == cct_pkg::ST_NUM) begin
         word_type = cct_pkg::TY_NUM;
      end else if (scan_ff == cct_pkg::ST_KW) begin
         word_type = cct_pkg::TY_KW;
      end else if (scan_ff == cct_pkg::ST_STR) begin
         word_type = cct_pkg::TY_STR;
      end
      wlen = (scan_ff == cct_pkg::ST_STR) ? rl_grow : rl_ff;
      if (wlen > RL_MAX) begin
         wlen_wide = 32'(RL_MAX);
         word_res  = cct_pkg::make_res(word_type, start_wide[31:0], wlen_wide[9:0],
                                       line_in, cct_pkg::RK_OVFL);
      end else begin
         wlen_wide = 32'(wlen);
         word_res  = cct_pkg::make_res(word_type, start_wide[31:0], wlen_wide[9:0],
                                       line_in, cct_pkg::RK_TOKEN);
      end
   end

   assign err_res   = cct_pkg::make_res(cct_pkg::TY_NUM, cur_wide[31:0], 10'd0, line_in,
                                        cct_pkg::RK_ERROR);
   assign op_cur    = cct_pkg::make_res(cct_pkg::TY_OP, cur_wide[31:0], 10'd1, line_in,
                                        cct_pkg::RK_TOKEN);
   assign op_prev   = cct_pkg::make_res(cct_pkg::TY_OP, prev_wide[31:0], 10'd1, line_in,
                                        cct_pkg::RK_TOKEN);
   assign asg_prev  = cct_pkg::make_res(cct_pkg::TY_ASSIGN, prev_wide[31:0], 10'd2,
                                        line_in, cct_pkg::RK_TOKEN);
   assign asg_start = cct_pkg::make_res(cct_pkg::TY_ASSIGN, start_wide[31:0], 10'd2,
                                        line_in, cct_pkg::RK_TOKEN);

   // Next state of the scanner.
   always_comb begin
      scan_in  = scan_ff;
      held_in  = held_ff;
      colon_in = colon_ff;
      start_in = start_ff;
      rl_in    = rl_ff;
      case (scan_ff)
         cct_pkg::ST_START: begin
            if (held_ff) begin
               held_in  = 1'b0;
               colon_in = 1'b0;
            end
            if (held_ff && colon_ff) begin
               if (cl != cct_pkg::CL_EQ) begin
                  scan_in = cct_pkg::ST_ERR;
               end
            end else begin
               case (cl)
                  cct_pkg::CL_OP, cct_pkg::CL_EQ, cct_pkg::CL_SEP: begin
                     scan_in = cct_pkg::ST_START;
                  end
                  cct_pkg::CL_QUOTE: begin
                     scan_in  = cct_pkg::ST_STR;
                     start_in = off_ff;
                     rl_in    = RL_W'(1);
                  end
                  cct_pkg::CL_ALPHA: begin
                     scan_in  = cct_pkg::ST_KW;
                     start_in = off_ff;
                     rl_in    = RL_W'(1);
                  end
                  cct_pkg::CL_DIGIT: begin
                     scan_in  = cct_pkg::ST_NUM;
                     start_in = off_ff;
                     rl_in    = RL_W'(1);
                  end
                  cct_pkg::CL_SPECIAL: begin
                     scan_in  = cct_pkg::ST_ID;
                     start_in = off_ff;
                     rl_in    = RL_W'(1);
                  end
                  cct_pkg::CL_COLON: begin
                     scan_in  = cct_pkg::ST_ASSIGN;
                     start_in = off_ff;
                     rl_in    = RL_W'(1);
                  end
                  default: begin
                     scan_in = cct_pkg::ST_ERR;
                  end
               endcase
            end
         end
         cct_pkg::ST_NUM, cct_pkg::ST_KW, cct_pkg::ST_ID: begin
            if (cont) begin
               rl_in = rl_grow;
            end else if (holds) begin
               held_in  = 1'b1;
               colon_in = (cl == cct_pkg::CL_COLON);
               scan_in  = cct_pkg::ST_START;
            end else if (cl == cct_pkg::CL_SEP) begin
               scan_in = cct_pkg::ST_START;
            end else begin
               scan_in = cct_pkg::ST_ERR;
            end
         end
         cct_pkg::ST_ASSIGN: begin
            scan_in = (cl == cct_pkg::CL_EQ) ? cct_pkg::ST_START : cct_pkg::ST_ERR;
         end
         cct_pkg::ST_STR: begin
            rl_in = rl_grow;
            if (cl == cct_pkg::CL_QUOTE) begin
               scan_in = cct_pkg::ST_START;
            end
         end
         default: begin
            scan_in = cct_pkg::ST_ERR;
         end
      endcase
   end

   // Results caused by the current byte.
   always_comb begin
      r0 = err_res;
      r1 = err_res;
      n  = 2'd0;
      case (scan_ff)
         cct_pkg::ST_START: begin
            if (held_ff && colon_ff) begin
               r0 = (cl == cct_pkg::CL_EQ) ? asg_prev : err_res;
               n  = 2'd1;
            end else begin
               if (held_ff) begin
                  r0 = op_prev;
               end
               if (cl == cct_pkg::CL_OP || cl == cct_pkg::CL_EQ) begin
                  if (held_ff) begin
                     r1 = op_cur;
                     n  = 2'd2;
                  end else begin
                     r0 = op_cur;
                     n  = 2'd1;
                  end
               end else if (cl == cct_pkg::CL_BAD) begin
                  if (held_ff) begin
                     r1 = err_res;
                     n  = 2'd2;
                  end else begin
                     r0 = err_res;
                     n  = 2'd1;
                  end
               end else if (held_ff) begin
                  n = 2'd1;
               end
            end
         end
         cct_pkg::ST_NUM, cct_pkg::ST_KW, cct_pkg::ST_ID: begin
            if (!cont) begin
               r0 = (holds || cl == cct_pkg::CL_SEP) ? word_res : err_res;
               n  = 2'd1;
            end
         end
         cct_pkg::ST_ASSIGN: begin
            r0 = (cl == cct_pkg::CL_EQ) ? asg_start : err_res;
            n  = 2'd1;
         end
         cct_pkg::ST_STR: begin
            if (cl == cct_pkg::CL_QUOTE) begin
               r0 = word_res;
               n  = 2'd1;
            end
         end
         default: begin
            n = 2'd0;
         end
      endcase
   end

   assign entry.r0  = r0;
   assign entry.r1  = r1;
   assign entry.two = (n == 2'd2);
   assign push      = accept && (n != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff  <= cct_pkg::ST_START;
         held_ff  <= 1'b0;
         colon_ff <= 1'b0;
         start_ff <= '0;
         rl_ff    <= '0;
         line_ff  <= 16'd1;
         off_ff   <= '0;
      end else if (accept) begin
         scan_ff  <= scan_in;
         held_ff  <= held_in;
         colon_ff <= colon_in;
         start_ff <= start_in;
         rl_ff    <= rl_in;
         line_ff  <= line_in;
         off_ff   <= off_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cct_fifo.sv =====
// ----------------------------------------------------------------------------
// cct_fifo
// Short queue of result entries between the scanner and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_fifo #(
   parameter int DEPTH = cct_pkg::FIFO_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  cct_pkg::cct_entry_type      push_data,
   output logic                        full,
   input  wire logic                   pop,
   output cct_pkg::cct_entry_type      pop_data,
   output logic                        empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   cct_pkg::cct_entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cct_back.sv =====
// ----------------------------------------------------------------------------
// cct_back
// Output register that takes queued entries and hands out one result per
// transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  cct_pkg::cct_entry_type      pop_data,
   input  wire logic                   empty,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [63:0]                 rsp_tdata,  // type, start, length, line
   output logic [1:0]                  rsp_tuser,  // report kind
   output logic                        rsp_tlast
);

   cct_pkg::cct_entry_type entry_ff, entry_in;
   logic                   valid_ff, valid_in;
   logic                   idx_ff, idx_in;
   cct_pkg::cct_res_type   res;
   logic                   done, load;

   assign done = valid_ff && rsp_tready && (idx_ff || !entry_ff.two);
   assign load = !valid_ff || done;
   assign pop  = load && !empty;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         entry_in = pop_data;
         valid_in = !empty;
         idx_in   = 1'b0;
      end else if (rsp_tready) begin
         idx_in = 1'b1;
      end
   end

   assign res        = idx_ff ? entry_ff.r1 : entry_ff.r0;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'd0, res.line, res.length, res.start, res.ttype};
   assign rsp_tuser  = res.kind;
   assign rsp_tlast  = idx_ff || !entry_ff.two;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire
